// ----- sv/llte_pkg.sv -----
// Package for the linked list table engine: types, constants, codes.
package llte_pkg;

    localparam int POOL_NODES_DEF = 16;

    typedef enum logic [2:0] {
        REQ_INS_END   = 3'd0,
        REQ_INS_FRONT = 3'd1,
        REQ_DEL_END   = 3'd2,
        REQ_DEL_FRONT = 3'd3,
        REQ_INS_AFTER = 3'd4,
        REQ_DEL_KEY   = 3'd5,
        REQ_TRAVERSE  = 3'd6,
        REQ_NONE      = 3'd7
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value;
        logic signed [31:0] key;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element;
        logic               last;
    } rsp_t;

    // Datapath commands from the controller
    typedef enum logic [3:0] {
        CMD_IDLE,     // hold
        CMD_LOAD,     // capture request, cur = head, prev = null
        CMD_READ,     // issue node read at cur
        CMD_STEP,     // prev = cur, cur = read next
        CMD_LINK_NEW, // write new node (value, next = link_src)
        CMD_SET_NEXT, // node_next[target] = link value
        CMD_SET_HEAD, // head = link value
        CMD_FREE_CUR, // free cur
        CMD_EMIT      // load output register
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [1:0] link_sel;   // 0 null, 1 new node, 2 read next, 3 head
        logic       tgt_prev;   // target of SET_NEXT: 1 prev, 0 cur
        logic [1:0] status;
        logic       elem_en;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic head_null;
        logic cur_null;
        logic prev_null;
        logic next_null;    // next of registered node read is null
        logic match;        // registered node value equals key
        logic full;
        logic bound;        // walk count reached pool size minus one
        logic [2:0] req_type;
    } stat_t;

    localparam logic [1:0] LINK_NULL = 2'd0;
    localparam logic [1:0] LINK_NEW  = 2'd1;
    localparam logic [1:0] LINK_RDN  = 2'd2;
    localparam logic [1:0] LINK_HEAD = 2'd3;

endpackage

// ----- sv/llte_dp.sv -----
// Datapath: node memories, head, free map, walk pointers, output register.
module llte_dp
    import llte_pkg::*;
#(
    parameter int POOL_NODES = POOL_NODES_DEF,
    parameter int IW = $clog2(POOL_NODES + 1)
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  req_t  req,
    input  cmd_t  cmd,
    output stat_t stat,
    input  logic  out_take,
    output logic  out_valid,
    output rsp_t  rsp
);
    localparam logic [IW-1:0] NULL_IDX = IW'(POOL_NODES);
    localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;

    logic signed [31:0] mem_val [POOL_NODES];
    logic [IW-1:0]      mem_nxt [POOL_NODES];

    logic [IW-1:0] head_reg, cur_reg, prev_reg, new_reg, cnt_reg;
    logic [POOL_NODES-1:0] free_reg;
    req_t req_reg;
    logic signed [31:0] rd_val_reg;
    logic [IW-1:0]      rd_nxt_reg;
    logic out_valid_reg;
    rsp_t rsp_reg;

    logic [IW-1:0] link;
    logic [IW-1:0] low_free;
    logic [IW-1:0] tgt;

    // lowest free node
    always_comb
    begin
        low_free = NULL_IDX;
        for (int i = POOL_NODES - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                low_free = IW'(i);
            end
        end
    end

    always_comb
    begin
        case (cmd.link_sel)
            LINK_NULL: link = NULL_IDX;
            LINK_NEW:  link = new_reg;
            LINK_RDN:  link = rd_nxt_reg;
            default:   link = head_reg;
        endcase
    end

    assign tgt = cmd.tgt_prev ? prev_reg : cur_reg;

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_READ && cur_reg != NULL_IDX)
        begin
            rd_val_reg <= mem_val[cur_reg[AW-1:0]];
            rd_nxt_reg <= mem_nxt[cur_reg[AW-1:0]];
        end
        if (cmd.op == CMD_LINK_NEW)
        begin
            mem_val[new_reg[AW-1:0]] <= req_reg.value;
            mem_nxt[new_reg[AW-1:0]] <= link;
        end
        else if (cmd.op == CMD_SET_NEXT)
        begin
            mem_nxt[tgt[AW-1:0]] <= link;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_LOAD)
        begin
            req_reg <= req;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= NULL_IDX;
            cur_reg       <= NULL_IDX;
            prev_reg      <= NULL_IDX;
            new_reg       <= NULL_IDX;
            cnt_reg       <= '0;
            free_reg      <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                CMD_LOAD:
                begin
                    cur_reg  <= head_reg;
                    prev_reg <= NULL_IDX;
                    cnt_reg  <= '0;
                    new_reg  <= low_free;
                end
                CMD_STEP:
                begin
                    prev_reg <= cur_reg;
                    cur_reg  <= rd_nxt_reg;
                    cnt_reg  <= cnt_reg + 1'b1;
                end
                CMD_LINK_NEW:
                begin
                    free_reg[new_reg[AW-1:0]] <= 1'b0;
                end
                CMD_SET_HEAD:
                begin
                    head_reg <= link;
                end
                CMD_FREE_CUR:
                begin
                    free_reg[cur_reg[AW-1:0]] <= 1'b1;
                end
                CMD_EMIT:
                begin
                    out_valid_reg  <= 1'b1;
                    rsp_reg.status <= cmd.status;
                    rsp_reg.element <= cmd.elem_en ? rd_val_reg : 32'sd0;
                    rsp_reg.last   <= cmd.last;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign stat.head_null = (head_reg == NULL_IDX);
    assign stat.cur_null  = (cur_reg == NULL_IDX);
    assign stat.prev_null = (prev_reg == NULL_IDX);
    assign stat.next_null = (rd_nxt_reg == NULL_IDX);
    assign stat.match     = (rd_val_reg == req_reg.key);
    assign stat.full      = (free_reg == '0);
    assign stat.bound     = (cnt_reg == IW'(POOL_NODES - 1));
    assign stat.req_type  = req_reg.req_type;

    assign out_valid = out_valid_reg;
    assign rsp       = rsp_reg;
endmodule

// ----- sv/llte_ctrl.sv -----
// Controller: sequences each request over the datapath.
module llte_ctrl
    import llte_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_stall,
    input  logic  out_busy,
    input  stat_t stat,
    output cmd_t  cmd
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DISP  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_EVAL  = 7'b0001000,
        S_FIX   = 7'b0010000,
        S_FREE  = 7'b0100000,
        S_WAIT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.op       = CMD_IDLE;
        cmd.last     = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = CMD_LOAD;
                    state_next = S_DISP;
                end
            end
            // decide first action once the output register is free
            S_DISP:
            begin
                if (!out_busy)
                begin
                    case (stat.req_type)
                        REQ_INS_FRONT:
                        begin
                            if (stat.full)
                            begin
                                cmd.op = CMD_EMIT; cmd.status = ST_FULL;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                cmd.op = CMD_LINK_NEW; cmd.link_sel = LINK_HEAD;
                                state_next = S_FIX;
                            end
                        end
                        REQ_INS_END:
                        begin
                            if (stat.full)
                            begin
                                cmd.op = CMD_EMIT; cmd.status = ST_FULL;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                cmd.op = CMD_LINK_NEW; cmd.link_sel = LINK_NULL;
                                state_next = stat.head_null ? S_FIX : S_READ;
                            end
                        end
                        REQ_DEL_END, REQ_DEL_FRONT, REQ_INS_AFTER,
                        REQ_DEL_KEY, REQ_TRAVERSE:
                        begin
                            if (stat.head_null)
                            begin
                                cmd.op = CMD_EMIT; cmd.status = ST_EMPTY;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                cmd.op = CMD_READ;
                                state_next = S_EVAL;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                cmd.op     = CMD_READ;
                state_next = S_EVAL;
            end
            // act on the node just read at cur
            S_EVAL:
            begin
                case (stat.req_type)
                    REQ_INS_END:
                    begin
                        if (stat.next_null || stat.bound)
                        begin
                            cmd.op = CMD_SET_NEXT; cmd.link_sel = LINK_NEW;
                            state_next = S_WAIT;
                        end
                        else
                        begin
                            cmd.op = CMD_STEP; state_next = S_READ;
                        end
                    end
                    REQ_DEL_END:
                    begin
                        if (stat.next_null || stat.bound)
                        begin
                            cmd.link_sel = LINK_NULL;
                            cmd.tgt_prev = 1'b1;
                            cmd.op = stat.prev_null ? CMD_SET_HEAD : CMD_SET_NEXT;
                            state_next = S_FREE;
                        end
                        else
                        begin
                            cmd.op = CMD_STEP; state_next = S_READ;
                        end
                    end
                    REQ_DEL_FRONT:
                    begin
                        cmd.op = CMD_SET_HEAD; cmd.link_sel = LINK_RDN;
                        state_next = S_FREE;
                    end
                    REQ_INS_AFTER:
                    begin
                        if (stat.match)
                        begin
                            if (stat.full)
                            begin
                                cmd.op = CMD_EMIT; cmd.status = ST_FULL;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                cmd.op = CMD_LINK_NEW; cmd.link_sel = LINK_RDN;
                                state_next = S_FIX;
                            end
                        end
                        else if (stat.next_null || stat.bound)
                        begin
                            cmd.op = CMD_EMIT; cmd.status = ST_NOT_FOUND;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.op = CMD_STEP; state_next = S_READ;
                        end
                    end
                    REQ_DEL_KEY:
                    begin
                        if (stat.match)
                        begin
                            cmd.link_sel = LINK_RDN;
                            cmd.tgt_prev = 1'b1;
                            cmd.op = stat.prev_null ? CMD_SET_HEAD : CMD_SET_NEXT;
                            state_next = S_FREE;
                        end
                        else if (stat.next_null || stat.bound)
                        begin
                            cmd.op = CMD_EMIT; cmd.status = ST_NOT_FOUND;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.op = CMD_STEP; state_next = S_READ;
                        end
                    end
                    default:
                    begin
                        // traverse: one result per node, wait for the taker
                        if (!out_busy)
                        begin
                            cmd.op      = CMD_EMIT;
                            cmd.status  = ST_OK;
                            cmd.elem_en = 1'b1;
                            cmd.last    = stat.next_null || stat.bound;
                            state_next  = (stat.next_null || stat.bound) ?
                                          S_IDLE : S_FIX;
                        end
                    end
                endcase
            end
            // second write step for inserts; traverse steps to the next node
            S_FIX:
            begin
                case (stat.req_type)
                    REQ_INS_FRONT, REQ_INS_END:
                    begin
                        cmd.op = CMD_SET_HEAD; cmd.link_sel = LINK_NEW;
                        state_next = S_WAIT;
                    end
                    REQ_INS_AFTER:
                    begin
                        cmd.op = CMD_SET_NEXT; cmd.link_sel = LINK_NEW;
                        state_next = S_WAIT;
                    end
                    default:
                    begin
                        cmd.op = CMD_STEP; state_next = S_READ;
                    end
                endcase
            end
            S_FREE:
            begin
                cmd.op     = CMD_FREE_CUR;
                state_next = S_WAIT;
            end
            default:
            begin
                cmd.op     = CMD_EMIT;
                cmd.status = ST_OK;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

// ----- sv/linked_list_table_engine.sv -----
// Insert at front: load, link the new node, set head, emit. Delete from front: load,
// read, set head, free, emit. End and key walks read and then step for each node.
// Traverse: one result per node; after each result it steps and reads the next node.
// Throughput: one request at a time; a waiting result lets the next request in.
// Reset (rst_n, async) empties the list and frees every node; no clearing pass.
module linked_list_table_engine
    import llte_pkg::*;
#(
    parameter int POOL_NODES = POOL_NODES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_stall,
    output rsp_t out_data
);
    cmd_t  cmd;
    stat_t stat;
    logic  busy;

    assign busy = out_valid && out_stall;

    llte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req_stall (in_stall),
        .out_busy  (busy),
        .stat      (stat),
        .cmd       (cmd)
    );

    llte_dp #(
        .POOL_NODES (POOL_NODES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_take  (out_valid && !out_stall),
        .out_valid (out_valid),
        .rsp       (out_data)
    );
endmodule
